>>> hw/rtl/dlq_pkg.sv
// shared types and constants for the doubly linked queue manager
// no dependencies
`default_nettype none
package dlq_pkg;
  localparam int unsigned DefEntries = 256;

  typedef enum logic [2:0] {
    CMD_INS_TAIL  = 3'd0,
    CMD_INS_GROUP = 3'd1,
    CMD_REM_HEAD  = 3'd2,
    CMD_REM_TAIL  = 3'd3,
    CMD_UNLINK    = 3'd4,
    CMD_CUR_RST   = 3'd5,
    CMD_CUR_NEXT  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD       = 3'd2,
    ST_BAD_GROUP = 3'd3,
    ST_CUR_END   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_CLEAR,
    S_GCHECK,
    S_GLAST,
    S_GAPPEND,
    S_CURSOR,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

>>> hw/rtl/dlq_ram.sv
// generic single port write, single port read ram with registered read
// no dependencies
`default_nettype none
module dlq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/doubly_linked_queue_manager_core.sv
// Doubly linked queue over ENTRIES entry indices. Requests arrive on the s_axis side
// (tdata = cmd, entry, group_size from the lowest bit) and one result per request leaves
// on m_axis (tdata = status, result_entry, queue_count, head_entry, tail_entry). Next and
// previous links sit in two rams with a registered read; the membership flag of each
// entry is kept beside its previous link. After reset the block clears the membership
// flag of every entry, with s_axis_tready low. One request is handled at a time; a request
// is settled at decode on range errors, an empty queue, a cursor reset, an empty group or
// an unknown command; a single insert, a cursor step or an unlink of a non-member ends after
// one ram read, a remove or unlink goes through link read, neighbour update and flag clear,
// and a group insert reads every membership flag of the group one a cycle and then appends
// one entry a cycle, stopping before the appends when an overlap is found. The output
// register lets the next request be taken while a result waits; a result that finds the
// register still full holds its last cycle until the register frees.
// depends on dlq_pkg and dlq_ram
`default_nettype none
module doubly_linked_queue_manager_core
  import dlq_pkg::*;
#(
  parameter int unsigned ENTRIES = DefEntries
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // cmd, entry, group_size
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // status, result_entry, queue_count, head, tail
);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned SW = (CW > 10) ? CW : 10;
  localparam logic [LW-1:0] NONE = LW'(ENTRIES);

  state_t state, state_next;

  logic [2:0]    cmd;
  logic [7:0]    ent;
  logic [8:0]    gsz;
  logic [IW-1:0] head_index, tail_index, cursor_pos, tgt, clr_idx;
  logic [CW-1:0] entry_count;
  logic          cursor_valid;
  logic [8:0]    gidx;
  logic          gbad;
  logic [2:0]    status;
  logic [7:0]    res;
  logic          out_valid;
  logic [39:0]   out_data;

  // link memories, membership flag above the previous link
  logic          nl_we, pl_we;
  logic [IW-1:0] nl_waddr, pl_waddr, nl_raddr, pl_raddr;
  logic [LW-1:0] nl_wdata, nl_rdata;
  logic [LW:0]   pl_wdata, pl_rdata;

  dlq_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(nl_raddr), .rdata(nl_rdata)
  );
  dlq_ram #(.WIDTH(LW + 1), .DEPTH(ENTRIES)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  logic          ent_ok, member_rd, n_ok, p_ok, is_head, is_tail;
  logic [IW-1:0] ent_i, target, gent;
  logic [SW-1:0] gend;
  logic [LW-1:0] p_link;

  assign ent_ok    = SW'(ent) < SW'(ENTRIES);
  assign ent_i     = IW'(ent);
  assign gend      = SW'(ent) + SW'(gsz);
  assign gent      = IW'(SW'(ent) + SW'(gidx));
  assign target    = (cmd == CMD_REM_HEAD) ? head_index :
                     (cmd == CMD_REM_TAIL) ? tail_index : ent_i;
  assign member_rd = pl_rdata[LW];
  assign p_link    = pl_rdata[LW-1:0];
  assign n_ok      = nl_rdata < NONE;
  assign p_ok      = p_link < NONE;
  assign is_head   = tgt == head_index;
  assign is_tail   = tgt == tail_index;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    nl_we = 1'b0; nl_waddr = tgt; nl_wdata = NONE;
    pl_we = 1'b0; pl_waddr = tgt; pl_wdata = {1'b0, NONE};
    nl_raddr = target; pl_raddr = target;
    case (state)
      S_INIT: begin
        pl_we = 1'b1; pl_waddr = clr_idx;
        if (clr_idx == IW'(ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd)
          CMD_INS_TAIL: state_next = ent_ok ? S_CHECK : S_DONE;
          CMD_INS_GROUP: state_next = (gsz == 9'd0 || !ent_ok ||
                                       gend > SW'(ENTRIES)) ? S_DONE : S_GCHECK;
          CMD_REM_HEAD, CMD_REM_TAIL: begin
            state_next = (entry_count == '0) ? S_DONE : S_CHECK;
          end
          CMD_UNLINK: begin
            state_next = (entry_count == '0 || !ent_ok) ? S_DONE : S_CHECK;
          end
          CMD_CUR_NEXT: begin
            nl_raddr = cursor_pos;
            state_next = S_CURSOR;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CHECK: begin
        if (cmd == CMD_INS_TAIL) begin
          if (!member_rd) begin
            pl_we = 1'b1; pl_waddr = tgt;
            pl_wdata = {1'b1, (entry_count == '0) ? NONE : LW'(tail_index)};
            nl_we = (entry_count != '0); nl_waddr = tail_index; nl_wdata = LW'(tgt);
          end
          state_next = S_DONE;
        end else if (!member_rd) begin
          state_next = S_DONE;
        end else begin
          // neighbours relinked here, the removed entry's flag next cycle
          if (!(is_head && is_tail)) begin
            if (is_head) begin
              pl_we = n_ok; pl_waddr = IW'(nl_rdata); pl_wdata = {1'b1, NONE};
            end else if (is_tail) begin
              nl_we = p_ok; nl_waddr = IW'(p_link); nl_wdata = NONE;
            end else if (n_ok && p_ok) begin
              pl_we = 1'b1; pl_waddr = IW'(nl_rdata); pl_wdata = {1'b1, p_link};
              nl_we = 1'b1; nl_waddr = IW'(p_link); nl_wdata = nl_rdata;
            end
          end
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        pl_we = 1'b1;
        state_next = S_DONE;
      end
      S_GCHECK: begin
        pl_raddr = gent;
        if (gidx + 9'd1 == gsz) begin
          state_next = S_GLAST;
        end
      end
      S_GLAST: state_next = (gbad || member_rd) ? S_DONE : S_GAPPEND;
      S_GAPPEND: begin
        pl_we = 1'b1; pl_waddr = gent;
        pl_wdata = {1'b1, (entry_count == '0) ? NONE : LW'(tail_index)};
        nl_we = (entry_count != '0); nl_waddr = tail_index; nl_wdata = LW'(gent);
        if (gidx + 9'd1 == gsz) begin
          state_next = S_DONE;
        end
      end
      S_CURSOR: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0; tail_index <= '0; entry_count <= '0;
      cursor_pos <= '0; cursor_valid <= 1'b0; clr_idx <= '0;
    end else begin
      case (state)
        S_INIT: clr_idx <= clr_idx + IW'(1);
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= s_axis_tdata[2:0];
            ent <= s_axis_tdata[10:3];
            gsz <= s_axis_tdata[19:11];
            status <= ST_OK; res <= '0; gidx <= '0; gbad <= 1'b0;
          end
        end
        S_DECODE: begin
          tgt <= target;
          case (cmd)
            CMD_INS_TAIL: begin
              if (!ent_ok) status <= ST_BAD;
            end
            CMD_INS_GROUP: begin
              if (gsz != 9'd0 && (!ent_ok || gend > SW'(ENTRIES))) begin
                status <= ST_BAD_GROUP;
              end
            end
            CMD_REM_HEAD, CMD_REM_TAIL: begin
              if (entry_count == '0) status <= ST_EMPTY;
            end
            CMD_UNLINK: begin
              if (entry_count == '0) begin
                status <= ST_EMPTY;
              end else if (!ent_ok) begin
                status <= ST_BAD;
              end
            end
            CMD_CUR_RST: begin
              cursor_valid <= 1'b0; cursor_pos <= '0;
            end
            CMD_CUR_NEXT: ;
            default: status <= ST_BAD;
          endcase
        end
        S_CHECK: begin
          if (cmd == CMD_INS_TAIL) begin
            if (member_rd) begin
              status <= ST_BAD;
            end else begin
              if (entry_count == '0) head_index <= tgt;
              tail_index <= tgt;
              entry_count <= entry_count + CW'(1);
            end
          end else if (!member_rd) begin
            status <= ST_BAD;
          end else begin
            if (is_head && is_tail) begin
              head_index <= '0; tail_index <= '0;
            end else if (is_head) begin
              if (n_ok) head_index <= IW'(nl_rdata);
            end else if (is_tail) begin
              if (p_ok) tail_index <= IW'(p_link);
            end
            entry_count <= entry_count - CW'(1);
            if (cmd != CMD_UNLINK) res <= 8'(tgt);
            if (cursor_valid && cursor_pos == tgt) begin
              cursor_valid <= 1'b0; cursor_pos <= '0;
            end
          end
        end
        S_GCHECK: begin
          // flag read lags the index, arriving in the cycle after it is addressed
          if (gidx != 9'd0 && member_rd) gbad <= 1'b1;
          if (gidx + 9'd1 == gsz) begin
            gidx <= '0;
          end else begin
            gidx <= gidx + 9'd1;
          end
        end
        S_GLAST: begin
          if (gbad || member_rd) status <= ST_BAD;
        end
        S_GAPPEND: begin
          if (entry_count == '0) head_index <= gent;
          tail_index <= gent;
          entry_count <= entry_count + CW'(1);
          gidx <= gidx + 9'd1;
        end
        S_CURSOR: begin
          if (entry_count != '0 && !cursor_valid) begin
            cursor_pos <= head_index; cursor_valid <= 1'b1; res <= 8'(head_index);
          end else if (entry_count != '0 && cursor_pos != tail_index && n_ok) begin
            cursor_pos <= IW'(nl_rdata); cursor_valid <= 1'b1; res <= 8'(nl_rdata);
          end else begin
            cursor_pos <= '0; cursor_valid <= 1'b0; status <= ST_CUR_END;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
      out_data  <= {4'd0,
                    (entry_count != '0) ? 8'(tail_index) : 8'd0,
                    (entry_count != '0) ? 8'(head_index) : 8'd0,
                    9'(entry_count), res, status};
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == S_DECODE)
    else $error("accepted request not decoded");
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(ENTRIES))
    else $error("count overflow");
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// self-checking testbench for doubly_linked_queue_manager_core
// drives queue requests on s_axis, checks every result on m_axis against a behavioural model
// depends on dlq_pkg and the core rtl
`default_nettype none
module testbench
  import dlq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N = 256;
  localparam int unsigned NoLink = 256;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] res;
    logic [8:0] count;
    logic [7:0] head;
    logic [7:0] tail;
  } qresult_t;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] entry;
    logic [8:0] gsize;
    bit         known;
    qresult_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // cmd[2:0], entry[10:3], group_size[19:11]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status, result_entry, queue_count, head, tail

  doubly_linked_queue_manager_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  int unsigned q_head, q_tail, q_count, cur_pos;
  bit          cur_valid;
  int unsigned nxt [N];
  int unsigned prv [N];
  bit          member [N];

  qresult_t    pending_results [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 24, recv_idle = 50;

  function automatic void append_entry(int unsigned e);
    nxt[e] = NoLink;
    if (q_count == 0) begin
      prv[e] = NoLink;
      q_head = e;
    end else begin
      prv[e] = q_tail;
      nxt[q_tail] = e;
    end
    q_tail = e;
    member[e] = 1'b1;
    q_count++;
  endfunction

  function automatic void detach_entry(int unsigned e);
    int unsigned n, p;
    n = nxt[e];
    p = prv[e];
    if (e == q_head && e == q_tail) begin
      q_head = 0;
      q_tail = 0;
    end else if (e == q_head) begin
      prv[n] = NoLink;
      q_head = n;
    end else if (e == q_tail) begin
      nxt[p] = NoLink;
      q_tail = p;
    end else begin
      prv[n] = p;
      nxt[p] = n;
    end
    member[e] = 1'b0;
    q_count--;
    if (cur_valid && cur_pos == e) begin
      cur_valid = 1'b0;
      cur_pos = 0;
    end
  endfunction

  function automatic qresult_t predict_queue_op(logic [2:0] cmd, logic [7:0] entry,
                                                logic [8:0] gsize);
    qresult_t    r;
    int unsigned nx;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_INS_TAIL: begin
        if (member[entry]) r.status = ST_BAD;
        else append_entry(entry);
      end
      CMD_INS_GROUP: begin
        if (gsize != 0) begin
          if (N - entry < gsize) r.status = ST_BAD_GROUP;
          else begin
            for (int i = 0; i < gsize; i++)
              if (member[entry + i]) r.status = ST_BAD;
            if (r.status == ST_OK)
              for (int i = 0; i < gsize; i++) append_entry(entry + i);
          end
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL: begin
        if (q_count == 0) r.status = ST_EMPTY;
        else begin
          r.res = (cmd == CMD_REM_HEAD) ? q_head[7:0] : q_tail[7:0];
          detach_entry(r.res);
        end
      end
      CMD_UNLINK: begin
        if (q_count == 0) r.status = ST_EMPTY;
        else if (!member[entry]) r.status = ST_BAD;
        else detach_entry(entry);
      end
      CMD_CUR_RST: begin
        cur_valid = 1'b0;
        cur_pos = 0;
      end
      CMD_CUR_NEXT: begin
        nx = NoLink;
        if (q_count != 0) begin
          if (!cur_valid) nx = q_head;
          else if (cur_pos != q_tail) nx = nxt[cur_pos];
        end
        if (nx < N) begin
          cur_pos = nx;
          cur_valid = 1'b1;
          r.res = nx[7:0];
        end else begin
          cur_pos = 0;
          cur_valid = 1'b0;
          r.status = ST_CUR_END;
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.count = q_count[8:0];
    r.head = (q_count != 0) ? q_head[7:0] : 8'd0;
    r.tail = (q_count != 0) ? q_tail[7:0] : 8'd0;
    return r;
  endfunction

  // valid stays up between back to back requests and drops only when the sender idles
  task automatic send_request(logic [2:0] cmd, logic [7:0] entry, logic [8:0] gsize,
                              bit known, qresult_t want);
    qresult_t r;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, gsize, entry, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = predict_queue_op(cmd, entry, gsize);
    if (known && r != want) begin
      $error("table row disagrees with model for cmd %0d", cmd);
      errors++;
    end
    pending_results.push_back(r);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver side
  always @(posedge clk) begin
    qresult_t got, exp_r;
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.res    = m_axis_tdata[10:3];
        got.count  = m_axis_tdata[19:11];
        got.head   = m_axis_tdata[27:20];
        got.tail   = m_axis_tdata[35:28];
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.status != exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, got.status); errors++;
          end
          if (got.res != exp_r.res) begin
            $error("result_entry expected %0d actual %0d", exp_r.res, got.res); errors++;
          end
          if (got.count != exp_r.count) begin
            $error("queue_count expected %0d actual %0d", exp_r.count, got.count); errors++;
          end
          if (got.head != exp_r.head) begin
            $error("head_entry expected %0d actual %0d", exp_r.head, got.head); errors++;
          end
          if (got.tail != exp_r.tail) begin
            $error("tail_entry expected %0d actual %0d", exp_r.tail, got.tail); errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
    if (cycles > 20000000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic qresult_t mk(int st, int re, int c, int h, int t);
    qresult_t r;
    r.status = 3'(st); r.res = 8'(re); r.count = 9'(c); r.head = 8'(h); r.tail = 8'(t);
    return r;
  endfunction

  dir_row_t dir_rows [$];

  task automatic random_request();
    logic [2:0] cmd;
    logic [7:0] e;
    logic [8:0] g;
    int unsigned k;
    k = $urandom_range(99);
    e = 8'($urandom);
    g = '0;
    if (k < 25) cmd = CMD_INS_TAIL;
    else if (k < 31) begin
      cmd = CMD_INS_GROUP;
      g = ($urandom_range(19) == 0) ? 9'($urandom_range(256)) : 9'($urandom_range(8));
    end else if (k < 42) cmd = CMD_REM_HEAD;
    else if (k < 50) cmd = CMD_REM_TAIL;
    else if (k < 66) begin
      cmd = CMD_UNLINK;
      // mostly pick a member so unlink reaches the middle of the list
      if (q_count != 0 && $urandom_range(3) != 0) begin
        do e = 8'($urandom); while (!member[e]);
      end
    end else if (k < 70) cmd = CMD_CUR_RST;
    else if (k < 97) cmd = CMD_CUR_NEXT;
    else begin
      cmd = 3'd7;
      g = 9'($urandom);
    end
    send_request(cmd, e, g, 1'b0, '0);
  endtask

  initial begin
    q_head = 0; q_tail = 0; q_count = 0; cur_pos = 0; cur_valid = 0;
    foreach (member[i]) begin
      member[i] = 0; nxt[i] = 0; prv[i] = 0;
    end
    // after reset, extremes and error codes are typed in
    dir_rows = '{
      '{CMD_REM_HEAD,  8'd0,   9'd0,   1'b1, mk(ST_EMPTY, 0, 0, 0, 0)},
      '{CMD_REM_TAIL,  8'd0,   9'd0,   1'b1, mk(ST_EMPTY, 0, 0, 0, 0)},
      '{CMD_UNLINK,    8'd5,   9'd0,   1'b1, mk(ST_EMPTY, 0, 0, 0, 0)},
      '{CMD_CUR_NEXT,  8'd0,   9'd0,   1'b1, mk(ST_CUR_END, 0, 0, 0, 0)},
      '{3'd7,          8'd255, 9'd511, 1'b1, mk(ST_BAD, 0, 0, 0, 0)},
      '{CMD_INS_GROUP, 8'd9,   9'd0,   1'b1, mk(ST_OK, 0, 0, 0, 0)},
      '{CMD_INS_GROUP, 8'd255, 9'd2,   1'b1, mk(ST_BAD_GROUP, 0, 0, 0, 0)},
      '{CMD_INS_GROUP, 8'd1,   9'd256, 1'b1, mk(ST_BAD_GROUP, 0, 0, 0, 0)},
      '{CMD_INS_TAIL,  8'd255, 9'd0,   1'b1, mk(ST_OK, 0, 1, 255, 255)},
      '{CMD_INS_TAIL,  8'd255, 9'd0,   1'b1, mk(ST_BAD, 0, 1, 255, 255)},
      '{CMD_INS_TAIL,  8'd0,   9'd0,   1'b1, mk(ST_OK, 0, 2, 255, 0)},
      '{CMD_INS_GROUP, 8'd10,  9'd4,   1'b0, '0},
      '{CMD_INS_GROUP, 8'd12,  9'd3,   1'b0, '0},
      '{CMD_UNLINK,    8'd100, 9'd0,   1'b0, '0},
      '{CMD_CUR_NEXT,  8'd0,   9'd0,   1'b0, '0},
      '{CMD_CUR_NEXT,  8'd0,   9'd0,   1'b0, '0},
      '{CMD_REM_TAIL,  8'd0,   9'd0,   1'b0, '0},
      '{CMD_UNLINK,    8'd0,   9'd0,   1'b0, '0},
      '{CMD_CUR_NEXT,  8'd0,   9'd0,   1'b0, '0},
      '{CMD_CUR_RST,   8'd0,   9'd0,   1'b0, '0},
      '{CMD_UNLINK,    8'd11,  9'd0,   1'b0, '0},
      '{CMD_REM_HEAD,  8'd0,   9'd0,   1'b0, '0},
      '{CMD_REM_HEAD,  8'd0,   9'd0,   1'b0, '0},
      '{CMD_REM_TAIL,  8'd0,   9'd0,   1'b0, '0},
      '{CMD_INS_GROUP, 8'd0,   9'd256, 1'b0, '0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_request(dir_rows[i].cmd, dir_rows[i].entry, dir_rows[i].gsize,
                   dir_rows[i].known, dir_rows[i].want);
    // drain the full queue so random traffic starts from nothing
    repeat (257) send_request(CMD_REM_HEAD, 8'd0, 9'd0, 1'b0, '0);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 50; recv_idle = 24;
      end else if (ph == 2) begin
        send_idle = 0; recv_idle = 0;
      end
      repeat (470) random_request();
      stop_sending();
      // hold off until the block has caught up
      while (pending_results.size() != 0) @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/dlq_pkg.sv
hw/rtl/dlq_ram.sv
hw/rtl/doubly_linked_queue_manager_core.sv
tb/sv/testbench.sv
